[rtl/pglm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_pkg
// Shared types and constants for the PCM gain and stereo level meter.
// ----------------------------------------------------------------------------
package pglm_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  localparam int VOL_W = 7;
  localparam logic [VOL_W-1:0] VOL_RESET = 7'd85;
  localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;

  localparam int MAG_W  = 16;
  localparam int PROD_W = 23;   // magnitude times volume, at most 3,276,800
  localparam int SQ_W   = 31;   // square of a scaled magnitude, at most 2^30

  // floor(x / 100) = (x * RECIP_100) >> 29 for x below 2^22
  localparam int RECIP_W = 23;
  localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
  localparam int RECIP_100_SH = 29;

  // floor(r * 32768 / 8000) = (r * RECIP_125) >> 20 for r below 8000
  localparam logic [RECIP_W-1:0] RECIP_125 = 23'd4294968;
  localparam int RECIP_125_SH = 20;
  localparam int ROOT_LOW_W = 13;

  localparam logic [15:0] RMS_FULL   = 16'd8000;
  localparam logic [15:0] LEVEL_FULL = 16'd32768;

  localparam int SQRT_STEPS = 16;
  localparam logic [31:0] SQRT_BIT_INIT = 32'h4000_0000;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               sample_valid;
    logic [15:0]        level;
    logic               level_updated;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               last;
    logic signed [15:0] smp;
    logic [SQ_W-1:0]    sq;
  } q_item_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_WAIT,
    BK_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    RM_IDLE,
    RM_DIV,
    RM_SQRT,
    RM_SCALE
  } rms_state_t;

endpackage
`default_nettype wire

[rtl/pcm_gain_stereo_level_meter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_gain_stereo_level_meter
// Volume scaler with a stereo output and a block RMS level meter.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the queue is full. Start and end words
// clear the meter and turn streaming on or off; while streaming is on,
// sample words are scaled by volume/100 (toward zero), sent out on both
// channels, and their squares are summed per block of BLOCK_LEN samples or
// up to a word marked last. Every word gives exactly one result word. Words
// that do not close a block go through at one per cycle while the output is
// not stalled. A word that closes a block passes through the bit-serial mean
// divider, the square-root unit and the level scaling; a four-word queue
// lets the front end keep taking words meanwhile. Write the volume only
// while no word is in flight.
// ----------------------------------------------------------------------------
module pcm_gain_stereo_level_meter #(
  parameter int BLOCK_LEN = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  pglm_pkg::in_item_t          src_data,
  output logic                        dst_valid,
  input  logic                        dst_stall,
  output pglm_pkg::out_item_t         dst_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pglm_pkg::VOL_W-1:0]  cfg_data
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_nonempty;
  pglm_pkg::q_item_t q_wdata;
  pglm_pkg::q_item_t q_head;

  pglm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .push      (q_push),
    .full      (q_full),
    .push_data (q_wdata)
  );

  pglm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  pglm_back #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_head    (q_head),
    .pop       (q_pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule
`default_nettype wire

[rtl/pglm_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_fifo
// Short queue of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
module pglm_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pglm_pkg::q_item_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output pglm_pkg::q_item_t  head
);

  pglm_pkg::q_item_t              mem [pglm_pkg::Q_DEPTH];
  logic [pglm_pkg::Q_AW-1:0]      wptr;
  logic [pglm_pkg::Q_AW-1:0]      rptr;
  logic [pglm_pkg::Q_AW:0]        fill;

  assign full     = (fill == (pglm_pkg::Q_AW + 1)'(pglm_pkg::Q_DEPTH));
  assign nonempty = (fill != '0);
  assign head     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/pglm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_front
// Accepts input words, tracks streaming, classifies each word and scales the
// sample by the volume in a three-stage pipeline feeding the queue.
// ----------------------------------------------------------------------------
module pglm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pglm_pkg::VOL_W-1:0]      cfg_data,
  input  logic                            src_valid,
  output logic                            src_stall,
  input  pglm_pkg::in_item_t              src_data,
  output logic                            push,
  input  logic                            full,
  output pglm_pkg::q_item_t               push_data
);

  logic [pglm_pkg::VOL_W-1:0]   volume;
  logic                         streaming_on;
  logic                         adv;
  logic                         accept;
  pglm_pkg::op_t                op_in;
  logic [pglm_pkg::MAG_W-1:0]   mag_in;

  logic                         v1, v2, v3;
  pglm_pkg::op_t                op1, op2, op3;
  logic                         neg1, neg2, neg3;
  logic                         last1, last2, last3;
  logic [pglm_pkg::MAG_W-1:0]   mag1;
  logic [pglm_pkg::PROD_W-1:0]  prod2;
  logic [pglm_pkg::MAG_W-1:0]   scaled3;

  logic [pglm_pkg::PROD_W+pglm_pkg::RECIP_W-1:0] recip_prod;
  logic [pglm_pkg::MAG_W-1:0]   smp_u;
  logic [2*pglm_pkg::MAG_W-1:0] sq_full;

  // advance the whole pipeline unless the last stage is blocked by a full queue
  assign adv       = !(v3 && full);
  assign src_stall = !adv;
  assign accept    = src_valid && adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    op_in = pglm_pkg::OP_NOP;
    case (src_data.mode)
      pglm_pkg::MODE_SAMPLE: begin
        if (streaming_on) begin
          op_in = pglm_pkg::OP_SAMPLE;
        end
      end
      pglm_pkg::MODE_START, pglm_pkg::MODE_END: begin
        op_in = pglm_pkg::OP_CLEAR;
      end
      default: begin
        op_in = pglm_pkg::OP_NOP;
      end
    endcase
  end

  assign mag_in = src_data.sample[15] ? pglm_pkg::MAG_W'(-src_data.sample)
                                      : pglm_pkg::MAG_W'(src_data.sample);

  assign recip_prod = (pglm_pkg::PROD_W + pglm_pkg::RECIP_W)'(prod2) *
                      (pglm_pkg::PROD_W + pglm_pkg::RECIP_W)'(pglm_pkg::RECIP_100);

  assign smp_u   = neg3 ? (~scaled3 + 1'b1) : scaled3;
  assign sq_full = (2 * pglm_pkg::MAG_W)'(scaled3) * (2 * pglm_pkg::MAG_W)'(scaled3);

  assign push           = v3 && !full;
  assign push_data.op   = op3;
  assign push_data.last = last3;
  assign push_data.smp  = signed'(smp_u);
  assign push_data.sq   = sq_full[pglm_pkg::SQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      volume       <= pglm_pkg::VOL_RESET;
      streaming_on <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        volume <= (cfg_data > pglm_pkg::VOL_MAX) ? pglm_pkg::VOL_MAX : cfg_data;
      end
      if (accept && (src_data.mode == pglm_pkg::MODE_START ||
                     src_data.mode == pglm_pkg::MODE_END)) begin
        streaming_on <= (src_data.mode == pglm_pkg::MODE_START);
      end
      if (adv) begin
        v1 <= accept;
        v2 <= v1;
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1     <= op_in;
      neg1    <= src_data.sample[15];
      last1   <= src_data.last;
      mag1    <= mag_in;

      op2     <= op1;
      neg2    <= neg1;
      last2   <= last1;
      prod2   <= pglm_pkg::PROD_W'(mag1) * pglm_pkg::PROD_W'(volume);

      op3     <= op2;
      neg3    <= neg2;
      last3   <= last2;
      scaled3 <= recip_prod[pglm_pkg::RECIP_100_SH +: pglm_pkg::MAG_W];
    end
  end

endmodule
`default_nettype wire

[rtl/pglm_rms.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_rms
// Block level unit: restoring divide of the square sum by the sample count,
// one bit a cycle, then a bit-pair integer square root, then Q15 scaling.
// ----------------------------------------------------------------------------
module pglm_rms #(
  parameter int BLOCK_LEN = 256
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [pglm_pkg::SQ_W+$clog2(BLOCK_LEN)-1:0]   dividend,
  input  logic [$clog2(BLOCK_LEN+1)-1:0]                divisor,
  output logic                                          done,
  output logic [15:0]                                   level
);

  localparam int CNT_W = $clog2(BLOCK_LEN + 1);
  localparam int SUM_W = pglm_pkg::SQ_W + $clog2(BLOCK_LEN);
  localparam int ITW   = $clog2(SUM_W);

  pglm_pkg::rms_state_t state, state_next;
  logic [ITW-1:0]       step;
  logic [SUM_W-1:0]     dvd;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dsr;
  logic [pglm_pkg::SQ_W-1:0] num;
  logic [31:0]          res;
  logic [31:0]          bitv;

  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic                 ge;
  logic [SUM_W-1:0]     dvd_next;
  logic [CNT_W-1:0]     rem_next;
  logic [32:0]          trial;
  logic                 take;
  logic [pglm_pkg::ROOT_LOW_W+pglm_pkg::RECIP_W-1:0] lvl_prod;

  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dsr};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign rem_next = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign dvd_next = {dvd[SUM_W-2:0], ge};

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign take  = ({2'b00, num} >= trial);

  assign lvl_prod = (pglm_pkg::ROOT_LOW_W + pglm_pkg::RECIP_W)'(res[pglm_pkg::ROOT_LOW_W-1:0]) *
                    (pglm_pkg::ROOT_LOW_W + pglm_pkg::RECIP_W)'(pglm_pkg::RECIP_125);

  assign done  = (state == pglm_pkg::RM_SCALE);
  assign level = (res[15:0] >= pglm_pkg::RMS_FULL) ? pglm_pkg::LEVEL_FULL
                                                   : lvl_prod[pglm_pkg::RECIP_125_SH +: 16];

  always_comb begin
    state_next = state;
    case (state)
      pglm_pkg::RM_IDLE: begin
        if (start) begin
          state_next = pglm_pkg::RM_DIV;
        end
      end
      pglm_pkg::RM_DIV: begin
        if (step == '0) begin
          state_next = pglm_pkg::RM_SQRT;
        end
      end
      pglm_pkg::RM_SQRT: begin
        if (step == '0) begin
          state_next = pglm_pkg::RM_SCALE;
        end
      end
      pglm_pkg::RM_SCALE: begin
        state_next = pglm_pkg::RM_IDLE;
      end
      default: begin
        state_next = pglm_pkg::RM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pglm_pkg::RM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pglm_pkg::RM_IDLE: begin
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        step <= ITW'(SUM_W - 1);
      end
      pglm_pkg::RM_DIV: begin
        dvd  <= dvd_next;
        rem  <= rem_next;
        step <= step - 1'b1;
        if (step == '0) begin
          // the mean never exceeds 2^30
          num  <= dvd_next[pglm_pkg::SQ_W-1:0];
          res  <= '0;
          bitv <= pglm_pkg::SQRT_BIT_INIT;
          step <= ITW'(pglm_pkg::SQRT_STEPS - 1);
        end
      end
      pglm_pkg::RM_SQRT: begin
        if (take) begin
          num <= num - trial[pglm_pkg::SQ_W-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        step <= step - 1'b1;
      end
      default: begin
        step <= step;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/pglm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pglm_back
// Executes queued words: accumulates squares, closes blocks through the
// level unit, and holds each result word in an output register.
// ----------------------------------------------------------------------------
module pglm_back #(
  parameter int BLOCK_LEN = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pglm_pkg::q_item_t   q_head,
  output logic                pop,
  output logic                dst_valid,
  input  logic                dst_stall,
  output pglm_pkg::out_item_t dst_data
);

  localparam int CNT_W = $clog2(BLOCK_LEN + 1);
  localparam int SUM_W = pglm_pkg::SQ_W + $clog2(BLOCK_LEN);

  pglm_pkg::back_state_t state, state_next;
  logic [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]      count;
  logic [15:0]           level_value;
  logic signed [15:0]    pend_smp;
  logic                  out_valid;
  pglm_pkg::out_item_t   out_data;

  logic                  slot_free;
  logic [SUM_W-1:0]      sum_inc;
  logic [CNT_W-1:0]      count_inc;
  logic                  close;
  logic                  rms_start;
  logic                  rms_done;
  logic [15:0]           rms_level;
  logic                  load;
  pglm_pkg::out_item_t   load_data;

  assign slot_free = !out_valid || !dst_stall;
  assign sum_inc   = sum + SUM_W'(q_head.sq);
  assign count_inc = count + 1'b1;
  assign close     = (count_inc == CNT_W'(BLOCK_LEN)) || q_head.last;

  assign dst_valid = out_valid;
  assign dst_data  = out_data;

  pglm_rms #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_rms (
    .clk      (clk),
    .rst      (rst),
    .start    (rms_start),
    .dividend (sum_inc),
    .divisor  (count_inc),
    .done     (rms_done),
    .level    (rms_level)
  );

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rms_start  = 1'b0;
    load       = 1'b0;
    load_data  = '0;
    case (state)
      pglm_pkg::BK_RUN: begin
        if (q_valid && slot_free) begin
          pop  = 1'b1;
          load = 1'b1;
          case (q_head.op)
            pglm_pkg::OP_SAMPLE: begin
              if (close) begin
                // hold the word until the block level is ready
                rms_start  = 1'b1;
                load       = 1'b0;
                state_next = pglm_pkg::BK_WAIT;
              end else begin
                load_data.left_sample  = q_head.smp;
                load_data.right_sample = q_head.smp;
                load_data.sample_valid = 1'b1;
                load_data.level        = level_value;
              end
            end
            pglm_pkg::OP_CLEAR: begin
              load_data.level_updated = 1'b1;
            end
            default: begin
              load_data.level = level_value;
            end
          endcase
        end
      end
      pglm_pkg::BK_WAIT: begin
        if (rms_done) begin
          state_next = pglm_pkg::BK_EMIT;
        end
      end
      pglm_pkg::BK_EMIT: begin
        if (slot_free) begin
          load                    = 1'b1;
          load_data.left_sample   = pend_smp;
          load_data.right_sample  = pend_smp;
          load_data.sample_valid  = 1'b1;
          load_data.level         = level_value;
          load_data.level_updated = 1'b1;
          state_next              = pglm_pkg::BK_RUN;
        end
      end
      default: begin
        state_next = pglm_pkg::BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pglm_pkg::BK_RUN;
      sum         <= '0;
      count       <= '0;
      level_value <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!dst_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (q_head.op)
          pglm_pkg::OP_SAMPLE: begin
            if (close) begin
              sum   <= '0;
              count <= '0;
            end else begin
              sum   <= sum_inc;
              count <= count_inc;
            end
          end
          pglm_pkg::OP_CLEAR: begin
            sum         <= '0;
            count       <= '0;
            level_value <= '0;
          end
          default: begin
            sum <= sum;
          end
        endcase
      end
      if (state == pglm_pkg::BK_WAIT && rms_done) begin
        level_value <= rms_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
    if (rms_start) begin
      pend_smp <= q_head.smp;
    end
  end

endmodule
`default_nettype wire

[tb/pcm_gain_stereo_level_meter_tb.sv]
// ----------------------------------------------------------------------------
// pcm_gain_stereo_level_meter_tb
// Self-checking bench for the volume scaler and block level meter.
// ----------------------------------------------------------------------------
// A queue of pending words feeds a clocked driver. A clocked monitor scores
// every accepted word against a bit-accurate gain and meter predictor and
// checks each result word against the oldest prediction. The volume changes
// between phases while nothing is in flight. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module pcm_gain_stereo_level_meter_tb;
  import pglm_pkg::*;

  localparam int BLOCK_WORDS = 256;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_WORDS = 80;

  logic clk = 1'b0;
  logic rst;
  logic src_valid;
  logic src_stall;
  in_item_t src_data;
  logic dst_valid;
  logic dst_stall;
  out_item_t dst_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [VOL_W-1:0] cfg_data;

  pcm_gain_stereo_level_meter #(.BLOCK_LEN(BLOCK_WORDS)) dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_data(src_data),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_data(dst_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [VOL_W-1:0] volume_pct;
  logic streaming;
  logic [63:0] sq_sum;
  int unsigned blk_cnt;
  logic [15:0] level_q15;

  in_item_t pending_words[$];
  out_item_t due_results[$];
  int words_queued;
  int words_taken;
  int results_seen;
  int mismatches;
  int volume_writes;
  int blocks_closed;
  int full_blocks;
  int clamped_levels;
  int dropped_samples;
  logic src_taken;
  logic no_gaps;
  int quiet_cycles;

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] trial;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = res | (64'd1 << i);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  function automatic out_item_t scale_and_meter(input in_item_t w);
    out_item_t r;
    logic [16:0] mag;
    logic [31:0] scaled;
    logic [63:0] lvl;
    r = '0;
    case (w.mode)
      MODE_START, MODE_END: begin
        streaming = (w.mode == MODE_START);
        sq_sum = '0;
        blk_cnt = 0;
        level_q15 = '0;
        r.level_updated = 1'b1;
      end
      MODE_SAMPLE: begin
        if (!streaming) begin
          dropped_samples++;
        end else begin
          mag = w.sample[15] ? (17'h10000 - {1'b0, w.sample}) : {1'b0, w.sample};
          scaled = (32'(mag) * 32'(volume_pct)) / 32'(VOL_MAX);
          r.left_sample = w.sample[15] ? 16'(32'd0 - scaled) : scaled[15:0];
          r.right_sample = r.left_sample;
          r.sample_valid = 1'b1;
          sq_sum = sq_sum + 64'(scaled) * 64'(scaled);
          blk_cnt++;
          if (blk_cnt >= BLOCK_WORDS || w.last) begin
            lvl = (root_floor(sq_sum / 64'(blk_cnt)) * 64'(LEVEL_FULL)) / 64'(RMS_FULL);
            if (lvl > 64'(LEVEL_FULL)) begin
              lvl = 64'(LEVEL_FULL);
              clamped_levels++;
            end
            if (blk_cnt >= BLOCK_WORDS) full_blocks++;
            blocks_closed++;
            level_q15 = lvl[15:0];
            sq_sum = '0;
            blk_cnt = 0;
            r.level_updated = 1'b1;
          end
        end
      end
      default: ;  // unused mode: no effect
    endcase
    r.level = level_q15;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // driver: change inputs at the falling edge, hold a word until taken
  always @(negedge clk) begin
    logic go;
    in_item_t w;
    if (!rst) begin
      if (!src_valid || src_taken) begin
        go = pending_words.size() > 0 && (no_gaps || $urandom_range(99) >= 37);
        if (go) begin
          w = pending_words.pop_front();
          src_data <= w;
        end
        src_valid <= go;
      end
      dst_stall <= !no_gaps && ($urandom_range(99) < 37);
    end
  end

  // monitor: predict on every accepted word, score every accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      src_taken = 1'b0;
    end else begin
      src_taken = src_valid && !src_stall;
      if (src_taken) begin
        due_results.push_back(scale_and_meter(src_data));
        words_taken++;
      end
      if (dst_valid && !dst_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected word, left_sample", dst_data.left_sample, 0);
        end else begin
          want = due_results.pop_front();
          if (dst_data.left_sample !== want.left_sample)
            report_mismatch("left_sample", dst_data.left_sample, want.left_sample);
          if (dst_data.right_sample !== want.right_sample)
            report_mismatch("right_sample", dst_data.right_sample, want.right_sample);
          if (dst_data.sample_valid !== want.sample_valid)
            report_mismatch("sample_valid", dst_data.sample_valid, want.sample_valid);
          if (dst_data.level !== want.level)
            report_mismatch("level", dst_data.level, want.level);
          if (dst_data.level_updated !== want.level_updated)
            report_mismatch("level_updated", dst_data.level_updated, want.level_updated);
        end
      end
    end
  end

  // watchdog: end the run when no handshake completes for too long
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (dst_valid && !dst_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results pending",
               quiet_cycles, due_results.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_word(input logic [1:0] mode, input logic [15:0] smp, input logic last);
    in_item_t w;
    w.mode = mode;
    w.sample = smp;
    w.last = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [15:0] pick_sample(input int loudness);
    int mag;
    case (loudness)
      0: return 16'($urandom());
      1: begin
        mag = $urandom_range(300);
        return $urandom_range(1) ? 16'(-mag) : 16'(mag);
      end
      2: begin
        mag = $urandom_range(12000);
        return $urandom_range(1) ? 16'(-mag) : 16'(mag);
      end
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'hffff;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  // a run of samples with one loudness, marked last at its end if asked
  task automatic add_chunk(input int len, input logic close_it);
    int loudness;
    loudness = $urandom_range(3);
    for (int i = 0; i < len; i++)
      add_word(MODE_SAMPLE, pick_sample(loudness), close_it && (i == len - 1));
  endtask

  // mostly start, chunks, end; the rest stray words
  task automatic add_random_traffic(input int count);
    int start_at;
    logic [1:0] noise_mode;
    start_at = words_queued;
    while (words_queued - start_at < count) begin
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(2))
          0: noise_mode = MODE_SAMPLE;
          1: noise_mode = MODE_END;
          default: noise_mode = MODE_UNUSED;
        endcase
        add_word(noise_mode, 16'($urandom()), 1'($urandom()));
      end else begin
        add_word(MODE_START, 16'($urandom()), 1'($urandom()));
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(99) < 3)
            add_chunk($urandom_range(256, 300), 1'b1);
          else
            add_chunk($urandom_range(1, 24), $urandom_range(99) < 85);
        end
        if ($urandom_range(1)) add_word(MODE_END, 16'($urandom()), 1'($urandom()));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (words_taken != words_queued || due_results.size() != 0);
  endtask

  task automatic write_volume(input logic [VOL_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    volume_pct = (v > VOL_MAX) ? VOL_MAX : v;
    volume_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [VOL_W-1:0] phase_vol[8];
    rst = 1'b1;
    src_valid = 1'b0;
    src_data = '0;
    dst_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_gaps = 1'b0;
    src_taken = 1'b0;
    quiet_cycles = 0;
    words_queued = 0;
    words_taken = 0;
    results_seen = 0;
    mismatches = 0;
    volume_writes = 0;
    blocks_closed = 0;
    full_blocks = 0;
    clamped_levels = 0;
    dropped_samples = 0;
    volume_pct = VOL_RESET;
    streaming = 1'b0;
    sq_sum = '0;
    blk_cnt = 0;
    level_q15 = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners at the reset volume
    add_word(MODE_SAMPLE, 16'h7fff, 1'b1);   // dropped while stopped
    add_word(MODE_END, 16'h0000, 1'b1);      // end while stopped
    add_word(MODE_UNUSED, 16'hffff, 1'b1);   // unused mode does nothing
    add_word(MODE_START, 16'h8000, 1'b1);    // last ignored on start
    add_word(MODE_SAMPLE, 16'h8000, 1'b0);
    add_word(MODE_SAMPLE, 16'h7fff, 1'b0);
    add_word(MODE_SAMPLE, 16'h0000, 1'b1);
    add_word(MODE_SAMPLE, 16'hffff, 1'b1);
    add_word(MODE_SAMPLE, 16'h0001, 1'b1);
    add_word(MODE_UNUSED, 16'h1234, 1'b0);
    add_word(MODE_SAMPLE, 16'd12345, 1'b0);
    add_word(MODE_START, 16'h7fff, 1'b0);    // restart drops the open block
    add_word(MODE_SAMPLE, 16'h8000, 1'b1);   // clamps at full level
    add_word(MODE_SAMPLE, 16'd100, 1'b0);
    add_word(MODE_END, 16'h5555, 1'b0);      // end drops the open block
    add_word(MODE_SAMPLE, 16'h8000, 1'b1);
    add_word(MODE_START, 16'h0000, 1'b0);
    add_word(MODE_SAMPLE, 16'd8000, 1'b1);
    wait_idle();

    phase_vol = '{VOL_MAX, 7'd0, 7'd127, 7'd1, 7'($urandom_range(127)), 7'd101,
                  7'($urandom_range(127)), 7'd50};
    for (int p = 0; p < 8; p++) begin
      write_volume(phase_vol[p]);
      no_gaps = (p == 3);
      if (p == 0) begin
        // exact full scale, then a block that fills to full length
        add_word(MODE_START, 16'h0000, 1'b0);
        add_word(MODE_SAMPLE, 16'd8000, 1'b1);
        add_word(MODE_SAMPLE, 16'h7fff, 1'b1);
        add_chunk(300, 1'b1);
      end
      add_random_traffic(PHASE_WORDS);
      wait_idle();
    end
    write_volume(VOL_RESET);
    add_random_traffic(40);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d words and %0d results over %0d volume settings.",
             words_taken, results_seen, volume_writes + 1);
    $display("Closed %0d blocks (%0d full length, %0d clamped), dropped %0d samples.",
             blocks_closed, full_blocks, clamped_levels, dropped_samples);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, due_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
